// ----- src/set_assoc_cache_tracker_defines.svh -----
// ---------------------------------------------------------------------------
// set associative cache tracker assertion macros
// shared assertion forms used by the tracker rtl
// ---------------------------------------------------------------------------
`ifndef SET_ASSOC_CACHE_TRACKER_DEFINES_SVH
`define SET_ASSOC_CACHE_TRACKER_DEFINES_SVH

// implication checked at every rising clock edge outside reset
`define SACT_ASSERT_IMP(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("assertion failed");

// next cycle implication checked outside reset
`define SACT_ASSERT_NXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("assertion failed");

`endif

// ----- src/sact_pkg.sv -----
// ---------------------------------------------------------------------------
// set associative cache tracker package
// shared types and constants
// ---------------------------------------------------------------------------
package sact_pkg;

   localparam int unsigned MEM_CYCLES_PER_WORD = 100;
   localparam int unsigned WORD_BYTES_LOG2     = 4 - 2;
   localparam int unsigned TAG_W               = 30;
   localparam int unsigned COST_W              = 18;

   typedef enum logic [2:0] {
      CSR_SETS_LOG2   = 3'd0,
      CSR_WAYS        = 3'd1,
      CSR_BLOCK_LOG2  = 3'd2,
      CSR_WRITE_ALLOC = 3'd3,
      CSR_WRITE_THRU  = 3'd4,
      CSR_USE_LRU     = 3'd5
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN,
      ST_VICTIM,
      ST_UPDATE,
      ST_RESP
   } state_type;

endpackage

// ----- src/set_assoc_cache_tracker.sv -----
// ---------------------------------------------------------------------------
// set associative cache tracker
// tag tracking for a set associative cache with lru or fifo replacement
// ---------------------------------------------------------------------------
// After reset the block clears its line state memory, one set per cycle,
// and is not ready meanwhile; configuration writes are taken as ever. Each
// transaction is accepted in an idle cycle; its set is then read and
// latched, and the ways are walked one per cycle through a single shared
// compare and rank unit: a scan pass, a victim pass on a miss that evicts,
// and an update pass. The running totals are then updated and the response
// is presented until it is taken; no new request is accepted before then.
// ---------------------------------------------------------------------------
module set_assoc_cache_tracker #(
   parameter int unsigned MAX_SETS = 1024,
   parameter int unsigned MAX_WAYS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write,
   input  logic [2:0]  csr_index,
   input  logic [4:0]  csr_data,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_type,
   input  logic [31:0] req_address,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_hit,
   output logic        rsp_allocated,
   output logic        rsp_evicted,
   output logic        rsp_wrote_back,
   output logic [17:0] rsp_access_cost,
   output logic [63:0] rsp_total_cycles,
   output logic [31:0] rsp_loads_seen,
   output logic [31:0] rsp_stores_seen,
   output logic [31:0] rsp_load_hits,
   output logic [31:0] rsp_load_misses,
   output logic [31:0] rsp_store_hits,
   output logic [31:0] rsp_store_misses
);
   import sact_pkg::*;
`include "set_assoc_cache_tracker_defines.svh"

   localparam int unsigned SET_W  = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
   localparam int unsigned WAY_W  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
   localparam int unsigned RANK_W = $clog2(MAX_WAYS + 1);
   localparam int unsigned KMAX   = $clog2(MAX_SETS + 1) - 1;
   localparam int unsigned LINE_W = TAG_W + 2 + RANK_W;
   localparam int unsigned ROW_W  = LINE_W * MAX_WAYS;

   // configuration
   logic [3:0] sets_log2_ff;
   logic [4:0] ways_ff;
   logic [3:0] blk_log2_ff;
   logic       walloc_ff, wthru_ff, lru_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sets_log2_ff <= 4'd0;
         ways_ff      <= 5'd1;
         blk_log2_ff  <= 4'd4;
         walloc_ff    <= 1'b1;
         wthru_ff     <= 1'b0;
         lru_ff       <= 1'b1;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_SETS_LOG2:   sets_log2_ff <= csr_data[3:0];
            CSR_WAYS:        ways_ff      <= csr_data;
            CSR_BLOCK_LOG2:  blk_log2_ff  <= csr_data[3:0];
            CSR_WRITE_ALLOC: walloc_ff    <= csr_data[0];
            CSR_WRITE_THRU:  wthru_ff     <= csr_data[0];
            CSR_USE_LRU:     lru_ff       <= csr_data[0];
            default: ;
         endcase
      end
   end

   // effective split
   logic [3:0]  eff_k, eff_off;
   logic [6:0]  eff_ways;
   logic [17:0] mem_cost;
   always_comb begin
      eff_k = (32'(sets_log2_ff) > KMAX) ? 4'(KMAX) : sets_log2_ff;
      if (ways_ff == 5'd0) eff_ways = 7'd1;
      else if (32'(ways_ff) > MAX_WAYS) eff_ways = 7'(MAX_WAYS);
      else eff_ways = 7'(ways_ff);
      if (blk_log2_ff < 4'd2) eff_off = 4'd2;
      else if (blk_log2_ff > 4'd12) eff_off = 4'd12;
      else eff_off = blk_log2_ff;
      mem_cost = 18'(MEM_CYCLES_PER_WORD) << (eff_off - 4'(WORD_BYTES_LOG2));
   end

   // line state memory, one row per set
   logic [ROW_W-1:0] mem [MAX_SETS];
   logic [ROW_W-1:0] rd_row_ff;
   logic [ROW_W-1:0] row_ff, row_in;
   logic             mem_we;
   logic [SET_W-1:0] mem_waddr;
   logic [ROW_W-1:0] mem_wdata;

   state_type        state_ff, state_in;
   logic [SET_W:0]   clr_ff, clr_in;
   logic [SET_W-1:0] set_ff, set_in;
   logic [TAG_W-1:0] tag_ff, tag_in;
   logic             store_ff, store_in;
   logic [WAY_W:0]   way_ff, way_in;
   logic             rd_pend_ff, rd_pend_in;
   logic             hit_ff, hit_in;
   logic [WAY_W-1:0] slot_ff, slot_in;
   logic             slot_found_ff, slot_found_in;
   logic [RANK_W-1:0] count_ff, count_in;
   logic [RANK_W-1:0] best_ff, best_in;
   logic             alloc_ff, alloc_in;
   logic             evict_ff, evict_in;
   logic             wb_ff, wb_in;
   logic [COST_W-1:0] cost_ff, cost_in;
   logic [63:0]      total_ff, total_in;
   logic             tally_inc;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_row_ff <= mem[set_ff];
   end

   // one way slice of the held row
   logic [WAY_W-1:0]  cur;
   logic [LINE_W-1:0] line;
   logic [TAG_W-1:0]  l_tag;
   logic              l_val;
   logic [RANK_W-1:0] l_rank;
   logic [RANK_W-1:0] gap_rank;
   logic              gap_on;
   logic [LINE_W-1:0] line_new;
   logic [31:0]       shifted;
   logic [64:0]       total_sum;

   always_comb begin
      cur     = way_ff[WAY_W-1:0];
      line    = row_ff[cur*LINE_W +: LINE_W];
      l_tag   = line[LINE_W-1 -: TAG_W];
      l_val   = line[RANK_W+1];
      l_rank  = line[RANK_W-1:0];
      shifted = req_address >> eff_off;
      total_sum = {1'b0, total_ff} + 65'(cost_ff);
   end

   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      set_in        = set_ff;
      tag_in        = tag_ff;
      store_in      = store_ff;
      way_in        = way_ff;
      rd_pend_in    = 1'b0;
      hit_in        = hit_ff;
      slot_in       = slot_ff;
      slot_found_in = slot_found_ff;
      count_in      = count_ff;
      best_in       = best_ff;
      alloc_in      = alloc_ff;
      evict_in      = evict_ff;
      wb_in         = wb_ff;
      cost_in       = cost_ff;
      total_in      = total_ff;
      row_in        = row_ff;
      mem_we        = 1'b0;
      mem_waddr     = set_ff;
      mem_wdata     = row_ff;
      tally_inc     = 1'b0;
      req_ready     = 1'b0;
      gap_on        = 1'b0;
      gap_rank      = '0;
      line_new      = line;

      unique case (state_ff)
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_ff[SET_W-1:0];
            mem_wdata = '0;
            clr_in    = clr_ff + 1'b1;
            if (32'(clr_ff) == MAX_SETS - 1) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               set_in        = SET_W'(shifted & ((32'd1 << eff_k) - 32'd1));
               tag_in        = TAG_W'(shifted >> eff_k);
               store_in      = req_type;
               way_in        = '0;
               rd_pend_in    = 1'b1;
               hit_in        = 1'b0;
               slot_found_in = 1'b0;
               slot_in       = '0;
               count_in      = '0;
               best_in       = '1;
               alloc_in      = 1'b0;
               evict_in      = 1'b0;
               wb_in         = 1'b0;
               cost_in       = COST_W'(1);
               state_in      = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (rd_pend_ff) begin
               // set read in flight
               rd_pend_in = 1'b0;
            end else if (way_ff == '0 && !slot_found_ff && count_ff == '0 && !hit_ff
                         && best_ff == '1 && !alloc_ff) begin
               // row latched once the set read has returned
               row_in   = rd_row_ff;
               best_in  = '0;
               alloc_in = 1'b1;
            end else begin
               if (l_val) begin
                  count_in = count_ff + 1'b1;
                  if (!hit_ff && l_tag == tag_ff) begin
                     hit_in  = 1'b1;
                     slot_in = cur;
                     best_in = l_rank;
                  end
               end else if (!slot_found_ff && !hit_ff) begin
                  slot_found_in = 1'b1;
                  slot_in       = cur;
               end
               way_in = way_ff + 1'b1;
               if (32'(way_ff) == MAX_WAYS - 1) begin
                  way_in   = '0;
                  alloc_in = 1'b0;
                  if (!hit_in) best_in = '1;
                  if (hit_in) begin
                     state_in = ST_UPDATE;
                  end else if (!store_ff || walloc_ff) begin
                     alloc_in = 1'b1;
                     cost_in  = cost_ff + mem_cost;
                     if (7'(count_in) >= eff_ways) begin
                        evict_in = 1'b1;
                        state_in = ST_VICTIM;
                     end else begin
                        state_in = ST_UPDATE;
                     end
                  end else begin
                     cost_in  = cost_ff + mem_cost;
                     state_in = ST_UPDATE;
                  end
               end
            end
         end
         ST_VICTIM: begin
            if (l_val && l_rank < best_ff) begin
               best_in = l_rank;
               slot_in = cur;
            end
            way_in = way_ff + 1'b1;
            if (32'(way_ff) == MAX_WAYS - 1) begin
               way_in = '0;
               wb_in  = row_ff[slot_in*LINE_W + RANK_W];
               if (wb_in) cost_in = cost_ff + mem_cost;
               count_in = count_ff - 1'b1;
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            if (hit_ff) begin
               gap_on   = lru_ff;
               gap_rank = best_ff;
            end else if (evict_ff) begin
               gap_on   = 1'b1;
               gap_rank = best_ff;
            end
            if (gap_on && l_val && cur != slot_ff && l_rank > gap_rank) begin
               line_new[RANK_W-1:0] = l_rank - 1'b1;
            end
            if (cur == slot_ff) begin
               if (hit_ff) begin
                  if (store_ff && !wthru_ff) line_new[RANK_W] = 1'b1;
                  if (lru_ff) line_new[RANK_W-1:0] = count_ff - 1'b1;
               end else if (alloc_ff) begin
                  line_new = {tag_ff, 1'b1, store_ff && !wthru_ff, count_ff};
               end
            end
            row_in[cur*LINE_W +: LINE_W] = line_new;
            way_in = way_ff + 1'b1;
            if (32'(way_ff) == MAX_WAYS - 1) begin
               way_in    = '0;
               mem_we    = 1'b1;
               mem_wdata = row_in;
               if (store_ff && hit_ff && wthru_ff)
                  cost_in = cost_ff + COST_W'(MEM_CYCLES_PER_WORD);
               state_in = ST_RESP;
            end
         end
         ST_RESP: begin
            if (way_ff == '0) begin
               total_in  = total_sum[64] ? '1 : total_sum[63:0];
               tally_inc = 1'b1;
               way_in    = {{WAY_W{1'b0}}, 1'b1};
            end else if (rsp_ready) begin
               way_in   = '0;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_CLEAR;
         clr_ff     <= '0;
         way_ff     <= '0;
         rd_pend_ff <= 1'b0;
         total_ff   <= '0;
      end else begin
         state_ff   <= state_in;
         clr_ff     <= clr_in;
         way_ff     <= way_in;
         rd_pend_ff <= rd_pend_in;
         total_ff   <= total_in;
      end
   end

   always_ff @(posedge clock) begin
      set_ff        <= set_in;
      tag_ff        <= tag_in;
      store_ff      <= store_in;
      hit_ff        <= hit_in;
      slot_ff       <= slot_in;
      slot_found_ff <= slot_found_in;
      count_ff      <= count_in;
      best_ff       <= best_in;
      alloc_ff      <= alloc_in;
      evict_ff      <= evict_in;
      wb_ff         <= wb_in;
      cost_ff       <= cost_in;
      row_ff        <= row_in;
   end

   sact_sat_counter #(.WIDTH(32)) u_loads (.clock(clock), .reset(reset),
      .inc(tally_inc && !store_ff), .value(rsp_loads_seen));
   sact_sat_counter #(.WIDTH(32)) u_stores (.clock(clock), .reset(reset),
      .inc(tally_inc && store_ff), .value(rsp_stores_seen));
   sact_sat_counter #(.WIDTH(32)) u_lhit (.clock(clock), .reset(reset),
      .inc(tally_inc && !store_ff && hit_ff), .value(rsp_load_hits));
   sact_sat_counter #(.WIDTH(32)) u_lmiss (.clock(clock), .reset(reset),
      .inc(tally_inc && !store_ff && !hit_ff), .value(rsp_load_misses));
   sact_sat_counter #(.WIDTH(32)) u_shit (.clock(clock), .reset(reset),
      .inc(tally_inc && store_ff && hit_ff), .value(rsp_store_hits));
   sact_sat_counter #(.WIDTH(32)) u_smiss (.clock(clock), .reset(reset),
      .inc(tally_inc && store_ff && !hit_ff), .value(rsp_store_misses));

   assign rsp_valid        = (state_ff == ST_RESP) && (way_ff != '0);
   assign rsp_hit          = hit_ff;
   assign rsp_allocated    = alloc_ff && !hit_ff;
   assign rsp_evicted      = evict_ff;
   assign rsp_wrote_back   = wb_ff;
   assign rsp_access_cost  = cost_ff;
   assign rsp_total_cycles = total_ff;

   `SACT_ASSERT_IMP(a_ready_idle, clock, reset, req_ready, !rsp_valid)
   `SACT_ASSERT_IMP(a_hit_no_evict, clock, reset, rsp_valid && rsp_hit, !rsp_evicted)
   `SACT_ASSERT_IMP(a_wb_evict, clock, reset, rsp_valid && rsp_wrote_back, rsp_evicted)
   `SACT_ASSERT_NXT(a_rsp_done, clock, reset, rsp_valid && rsp_ready, req_ready)
endmodule

// ----- src/sact_sat_counter.sv -----
// ---------------------------------------------------------------------------
// saturating tally counter
// increments by one on request and holds at all ones
// ---------------------------------------------------------------------------
module sact_sat_counter #(
   parameter int unsigned WIDTH = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             inc,
   output logic [WIDTH-1:0] value
);
   logic [WIDTH-1:0] count_ff;
   logic [WIDTH-1:0] count_in;

   always_comb begin
      count_in = count_ff;
      if (inc && (count_ff != {WIDTH{1'b1}})) begin
         count_in = count_ff + {{(WIDTH-1){1'b0}}, 1'b1};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   assign value = count_ff;
endmodule
